// File: sv/assert_macros.svh
// concurrent assertion helpers, clocked by clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define C420_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define C420_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define C420_ASSERT(lbl, prop, msg)

`define C420_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: sv/c420_pkg.sv
package c420_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned ACC_W  = 12;
  localparam int unsigned QDEPTH = 2;

  localparam logic [ACC_W-1:0] RND_EVEN = ACC_W'(8);
  localparam logic [ACC_W-1:0] RND_ODD  = ACC_W'(7);
  localparam int unsigned      OUT_SHIFT = 4;

  // one queued column: its two column sums and how the back end must treat it
  typedef struct packed {
    logic [SUM_W-1:0] sum_up;
    logic [SUM_W-1:0] sum_lo;
    logic             emit_held;
    logic             row_end;
  } c420_col_t;

  function automatic logic [SUM_W-1:0] c420_col_sum(
    input logic [PIX_W-1:0] centre,
    input logic [PIX_W-1:0] side
  );
    logic [SUM_W-1:0] s;
    s = {1'b0, centre, 1'b0} + {2'b00, centre} + {2'b00, side};
    return s;
  endfunction

  // 3:1 weight with neighbour, or 4 times itself at a row edge
  function automatic logic [PIX_W-1:0] c420_tap(
    input logic [SUM_W-1:0] here,
    input logic [SUM_W-1:0] nbr,
    input logic             edge_col,
    input logic [ACC_W-1:0] rnd
  );
    logic [ACC_W-1:0] acc;
    if (edge_col) begin
      acc = {here, 2'b00} + rnd;
    end else begin
      acc = {2'b00, here} + {1'b0, here, 1'b0} + {2'b00, nbr} + rnd;
    end
    return acc[OUT_SHIFT +: PIX_W];
  endfunction

endpackage

// File: sv/c420_if.sv
interface c420_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] above_pixel;
  logic [7:0] centre_pixel;
  logic [7:0] below_pixel;
  logic       row_end;

  modport source (output valid, above_pixel, centre_pixel, below_pixel, row_end,
                  input ready);
  modport sink   (input valid, above_pixel, centre_pixel, below_pixel, row_end,
                  output ready);
endinterface

interface c420_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] upper_even;
  logic [7:0] upper_odd;
  logic [7:0] lower_even;
  logic [7:0] lower_odd;
  logic       row_done;

  modport source (output valid, upper_even, upper_odd, lower_even, lower_odd, row_done,
                  input ready);
  modport sink   (input valid, upper_even, upper_odd, lower_even, lower_odd, row_done,
                  output ready);
endinterface

// File: sv/c420_front.sv
`include "assert_macros.svh"

module c420_front (
  input  logic                clk,
  input  logic                rst_n,
  c420_in_if.sink             in_chan,
  output logic                push_o,
  output c420_pkg::c420_col_t push_data_o,
  input  logic                q_full_i
);
  import c420_pkg::*;

  logic held_r;

  assign in_chan.ready = !q_full_i;
  assign push_o        = in_chan.valid && !q_full_i;

  always_comb begin
    push_data_o.sum_up    = c420_col_sum(in_chan.centre_pixel, in_chan.above_pixel);
    push_data_o.sum_lo    = c420_col_sum(in_chan.centre_pixel, in_chan.below_pixel);
    push_data_o.emit_held = held_r;
    push_data_o.row_end   = in_chan.row_end;
  end

  // a column stays held until its right neighbour or the row end shows up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (push_o) begin
      held_r <= !in_chan.row_end;
    end
  end

  `C420_ASSERT(a_row_end_drops_held, (push_o && in_chan.row_end) |=> !held_r, "held after row end")

endmodule

// File: sv/c420_colq.sv
`include "assert_macros.svh"

module c420_colq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  c420_pkg::c420_col_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output c420_pkg::c420_col_t head_o
);
  import c420_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  c420_col_t         mem_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full_o       = (count_r == CW'(QDEPTH));
  assign head_valid_o = (count_r != '0);
  assign head_o       = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop_i) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      case ({push_i, pop_i})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  `C420_ASSERT_NEVER(a_push_when_full, push_i && full_o, "push into full queue")
  `C420_ASSERT_NEVER(a_pop_when_empty, pop_i && !head_valid_o, "pop from empty queue")

endmodule

// File: sv/c420_back.sv
`include "assert_macros.svh"

module c420_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid_i,
  input  c420_pkg::c420_col_t head_i,
  output logic                pop_o,
  c420_out_if.source          out_chan
);
  import c420_pkg::*;

  typedef enum logic {PH_MAIN, PH_TAIL} phase_t;

  phase_t           phase_r;
  logic             first_r;
  logic [SUM_W-1:0] prev_up_r, prev_lo_r, cur_up_r, cur_lo_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] up_even_r, up_odd_r, lo_even_r, lo_odd_r;
  logic             row_done_r;

  logic             emit_req, out_free, step, use_head, first_sel, last_sel;
  logic [SUM_W-1:0] here_up, here_lo;

  always_comb begin
    emit_req  = head_valid_i && ((phase_r == PH_TAIL) || head_i.emit_held || head_i.row_end);
    out_free  = !out_valid_r || out_chan.ready;
    step      = head_valid_i && (!emit_req || out_free);
    // column arriving with nothing held is emitted straight from the queue head
    use_head  = (phase_r == PH_MAIN) && !head_i.emit_held;
    first_sel = use_head || first_r;
    last_sel  = (phase_r == PH_TAIL) || !head_i.emit_held;
    here_up   = use_head ? head_i.sum_up : cur_up_r;
    here_lo   = use_head ? head_i.sum_lo : cur_lo_r;
    pop_o     = step && !((phase_r == PH_MAIN) && head_i.emit_held && head_i.row_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAIN;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        unique case (phase_r)
          PH_TAIL: begin
            phase_r <= PH_MAIN;
            first_r <= 1'b1;
          end
          PH_MAIN: begin
            if (head_i.emit_held) begin
              prev_up_r <= cur_up_r;
              prev_lo_r <= cur_lo_r;
              first_r   <= 1'b0;
              phase_r   <= head_i.row_end ? PH_TAIL : PH_MAIN;
            end else begin
              first_r   <= 1'b1;
            end
            cur_up_r <= head_i.sum_up;
            cur_lo_r <= head_i.sum_lo;
          end
          default: phase_r <= PH_MAIN;
        endcase
      end
      if (step && emit_req) begin
        out_valid_r <= 1'b1;
        up_even_r   <= c420_tap(here_up, prev_up_r, first_sel, RND_EVEN);
        up_odd_r    <= c420_tap(here_up, head_i.sum_up, last_sel, RND_ODD);
        lo_even_r   <= c420_tap(here_lo, prev_lo_r, first_sel, RND_EVEN);
        lo_odd_r    <= c420_tap(here_lo, head_i.sum_lo, last_sel, RND_ODD);
        row_done_r  <= last_sel;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.upper_even = up_even_r;
  assign out_chan.upper_odd  = up_odd_r;
  assign out_chan.lower_even = lo_even_r;
  assign out_chan.lower_odd  = lo_odd_r;
  assign out_chan.row_done   = row_done_r;

  `C420_ASSERT(a_tail_needs_row_end, (phase_r == PH_TAIL) |-> (head_valid_i && head_i.row_end), "tail without row end")
  `C420_ASSERT(a_tail_restarts_row, (phase_r == PH_TAIL && step) |=> (first_r && phase_r == PH_MAIN), "row not restarted")

endmodule

// File: sv/chroma_420_bilinear_upsampler.sv
// 4:2:0 chroma upsampler, triangle (3:1) filter in both directions. Each input
// transaction is one source column (above, centre and below samples); each output
// transaction carries the two upper-row and two lower-row pixels of one source column.
// A column's result leaves once the next column arrives, so output lags by one
// column; the row_end column flushes both the held column and itself. Between row
// ends the sustained rate is one column per clock while the output is not stalled. A
// row_end column that follows a held column passes through PH_MAIN and then PH_TAIL
// in the back end, since both of its results leave through the one output register;
// a one-column row needs only PH_MAIN. The two-entry column queue between the front
// and the back end absorbs output stalls and the PH_TAIL step when the input has
// gaps; in an unbroken stream the queue fills and the input is held off at each such
// row end.
module chroma_420_bilinear_upsampler (
  input  logic       clk,
  input  logic       rst_n,
  c420_in_if.sink    in_chan,
  c420_out_if.source out_chan
);
  import c420_pkg::*;

  logic      push, q_full, pop, head_valid;
  c420_col_t push_data, head;

  c420_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  c420_colq u_colq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  c420_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_chan     (out_chan)
  );

endmodule

// File: test/tb_chroma_420_bilinear_upsampler.sv
`timescale 1ns / 100ps

module tb_chroma_420_bilinear_upsampler;
  import c420_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] below;
    logic             row_end;
  } column_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper_even;
    logic [PIX_W-1:0] upper_odd;
    logic [PIX_W-1:0] lower_even;
    logic [PIX_W-1:0] lower_odd;
    logic             row_done;
  } pixel_quad_t;

  typedef struct packed {
    column_t     col;
    logic        typed;
    pixel_quad_t quad;
  } directed_row_t;

  localparam logic        TYPED     = 1'b1;
  localparam logic        PREDICTED = 1'b0;
  localparam pixel_quad_t NO_QUAD   = '0;
  localparam int          NUM_DIRECTED  = 19;
  localparam int          RAND_COLUMNS  = 1330;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          CYCLE_LIMIT   = 200000;

  // one-column rows first (known answers), then multi-column rows through the predictor
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{8'd0,   8'd0,   8'd0,   1'b1}, TYPED, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1}},
    '{'{8'd255, 8'd255, 8'd255, 1'b1}, TYPED, '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
    '{'{8'd255, 8'd0,   8'd0,   1'b1}, TYPED, '{8'd64,  8'd64,  8'd0,   8'd0,   1'b1}},
    '{'{8'd0,   8'd255, 8'd255, 1'b1}, TYPED, '{8'd191, 8'd191, 8'd255, 8'd255, 1'b1}},
    '{'{8'd0,   8'd2,   8'd0,   1'b1}, TYPED, '{8'd2,   8'd1,   8'd2,   8'd1,   1'b1}},
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd255, 8'd255, 8'd255, 1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd0,   8'd0,   8'd0,   1'b1}, PREDICTED, NO_QUAD},
    '{'{8'd255, 8'd255, 8'd255, 1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd0,   8'd0,   8'd0,   1'b1}, PREDICTED, NO_QUAD},
    '{'{8'd255, 8'd0,   8'd255, 1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd0,   8'd255, 8'd0,   1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd128, 8'd127, 8'd1,   1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd7,   8'd8,   8'd254, 1'b1}, PREDICTED, NO_QUAD},
    '{'{8'd0,   8'd2,   8'd0,   1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd0,   8'd2,   8'd0,   1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd0,   8'd2,   8'd0,   1'b1}, PREDICTED, NO_QUAD},
    '{'{8'd255, 8'd255, 8'd0,   1'b0}, PREDICTED, NO_QUAD},
    '{'{8'd0,   8'd0,   8'd255, 1'b1}, PREDICTED, NO_QUAD}
  };

  logic clk;
  logic rst_n;

  c420_in_if  in_chan ();
  c420_out_if out_chan ();

  chroma_420_bilinear_upsampler DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pixel_quad_t      pending_quads[$];
  logic [SUM_W-1:0] left_sum_up = '0;
  logic [SUM_W-1:0] left_sum_lo = '0;
  logic [SUM_W-1:0] held_sum_up = '0;
  logic [SUM_W-1:0] held_sum_lo = '0;
  bit               have_held = 1'b0;
  bit               held_starts_row = 1'b1;

  int  mismatches = 0;
  int  quads_checked = 0;
  int  columns_sent = 0;
  int  rows_sent = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;
  bit  stall_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] even_tap(logic [SUM_W-1:0] here,
                                                logic [SUM_W-1:0] left, bit first);
    int acc;
    acc = first ? 4 * int'(here) + 8 : 3 * int'(here) + int'(left) + 8;
    return PIX_W'(acc >> 4);
  endfunction

  function automatic logic [PIX_W-1:0] odd_tap(logic [SUM_W-1:0] here,
                                               logic [SUM_W-1:0] right, bit last);
    int acc;
    acc = last ? 4 * int'(here) + 7 : 3 * int'(here) + int'(right) + 7;
    return PIX_W'(acc >> 4);
  endfunction

  function automatic pixel_quad_t held_quad(logic [SUM_W-1:0] right_up,
                                            logic [SUM_W-1:0] right_lo, bit last);
    pixel_quad_t q;
    q.upper_even = even_tap(held_sum_up, left_sum_up, held_starts_row);
    q.upper_odd  = odd_tap(held_sum_up, right_up, last);
    q.lower_even = even_tap(held_sum_lo, left_sum_lo, held_starts_row);
    q.lower_odd  = odd_tap(held_sum_lo, right_lo, last);
    q.row_done   = last;
    return q;
  endfunction

  // advance the filter state by one column, queueing the quads it completes
  task automatic upsample_column(input column_t col, input bit queue_quads);
    logic [SUM_W-1:0] new_up;
    logic [SUM_W-1:0] new_lo;
    new_up = SUM_W'(3 * int'(col.centre) + int'(col.above));
    new_lo = SUM_W'(3 * int'(col.centre) + int'(col.below));
    if (have_held) begin
      if (queue_quads) pending_quads.push_back(held_quad(new_up, new_lo, 1'b0));
      left_sum_up = held_sum_up;
      left_sum_lo = held_sum_lo;
      held_starts_row = 1'b0;
    end else begin
      held_starts_row = 1'b1;
    end
    held_sum_up = new_up;
    held_sum_lo = new_lo;
    have_held = 1'b1;
    if (col.row_end) begin
      if (queue_quads) pending_quads.push_back(held_quad('0, '0, 1'b1));
      have_held = 1'b0;
      held_starts_row = 1'b1;
      rows_sent++;
    end
  endtask

  task automatic send_column(input column_t col, input logic typed, input pixel_quad_t quad);
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.above_pixel  <= col.above;
    in_chan.centre_pixel <= col.centre;
    in_chan.below_pixel  <= col.below;
    in_chan.row_end      <= col.row_end;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    columns_sent++;
    upsample_column(col, !typed);
    if (typed) pending_quads.push_back(quad);
  endtask

  task automatic check_field(input string name, input logic [PIX_W-1:0] exp_v,
                             input logic [PIX_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // result side: check each output transaction, then pick next ready
  initial begin
    int          hold_left;
    pixel_quad_t exp_q;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (pending_quads.size() == 0) begin
          $error("output transaction with nothing expected");
          mismatches++;
        end else begin
          exp_q = pending_quads.pop_front();
          check_field("upper_even", exp_q.upper_even, out_chan.upper_even);
          check_field("upper_odd", exp_q.upper_odd, out_chan.upper_odd);
          check_field("lower_even", exp_q.lower_even, out_chan.lower_even);
          check_field("lower_odd", exp_q.lower_odd, out_chan.lower_odd);
          check_field("row_done", PIX_W'(exp_q.row_done), PIX_W'(out_chan.row_done));
          quads_checked++;
        end
      end
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= steady || $urandom_range(0, 99) >= 11;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_quads.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    column_t col;
    int      row_len;
    int      k;
    bit      stalled;
    bit      paused;
    stalled = 1'b0;
    paused  = 1'b0;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.above_pixel  <= '0;
    in_chan.centre_pixel <= '0;
    in_chan.below_pixel  <= '0;
    in_chan.row_end      <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_column(DIRECTED[i].col, DIRECTED[i].typed, DIRECTED[i].quad);

    while (columns_sent < NUM_DIRECTED + RAND_COLUMNS) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      for (k = 0; k < row_len; k++) begin
        col.above   = rand_pixel();
        col.centre  = rand_pixel();
        col.below   = rand_pixel();
        col.row_end = (k == row_len - 1);
        steady = (columns_sent >= 600 && columns_sent < 900);
        if (!stalled && columns_sent >= 300) begin
          stalled = 1'b1;
          stall_request = 1'b1;
        end
        send_column(col, PREDICTED, NO_QUAD);
      end
      // sender pause until every result of the finished rows has drained
      if (!paused && columns_sent >= 1000) begin
        paused = 1'b1;
        in_chan.valid <= 1'b0;
        while (pending_quads.size() != 0) @(posedge clk);
      end
    end
    in_chan.valid <= 1'b0;
    steady = 1'b0;

    while (pending_quads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_quads.size() != 0) begin
      $error("%0d expected results never arrived", pending_quads.size());
      mismatches++;
    end

    $display("sent %0d columns in %0d rows, checked %0d output quads in %0d cycles",
             columns_sent, rows_sent, quads_checked, cycle_count);
    $display("included one-column rows, pixel extremes, a long output hold-off and a drain pause");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
